// ===== rtl/dpcm_pkg.sv =====
// Package with types, coefficient tables and arithmetic helpers for the dichromat color map.
`timescale 1ns / 1ps
package dpcm_pkg;

  localparam int COEF_FRAC_BITS = 16;
  localparam longint DEC_SCALE = 64'd100000000;
  localparam longint DEC_HALF = DEC_SCALE / 2;

  // Coefficient magnitudes stay below 4, so two integer bits plus sign suffice.
  localparam int COEF_W = COEF_FRAC_BITS + 3;
  localparam int PROD_W = COEF_W + 9;
  localparam int SUM_W = PROD_W + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 2);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       plane_select;
  } out_item_t;

  // A classified color on its way from the front end to the back end.
  typedef struct packed {
    in_item_t pix;
    logic     plane;
  } mid_item_t;

  typedef struct packed {
    logic empty;
    cnt_t count;
  } mq_status_t;

  // Coefficients are given in units of 1e-8 and rounded half away from zero.
  function automatic coef_t quantize(input longint e8);
    longint mag;
    longint q;
    mag = (e8 < 0) ? -e8 : e8;
    q = ((mag << COEF_FRAC_BITS) + DEC_HALF) / DEC_SCALE;
    return COEF_W'((e8 < 0) ? -q : q);
  endfunction

  localparam coef_t CMP_LO [0:2] = '{quantize(64'sd999000), quantize(64'sd6647390),
                                     quantize(64'sd73170000)};
  localparam coef_t CMP_HI [0:2] = '{quantize(64'sd15338400), quantize(64'sd31662400),
                                     quantize(64'sd5713400)};

  localparam coef_t MAT_A [0:2][0:2] = '{
    '{quantize(64'sd42633100), quantize(64'sd87510200), quantize(64'sd8012710)},
    '{quantize(64'sd28110000), quantize(64'sd57119500), quantize(-64'sd3926270)},
    '{quantize(-64'sd1770520), quantize(64'sd2700840), quantize(64'sd100247000)}
  };

  localparam coef_t MAT_B [0:2][0:2] = '{
    '{quantize(64'sd75810000), quantize(64'sd145387000), quantize(-64'sd148060000)},
    '{quantize(64'sd11853200), quantize(64'sd28759500), quantize(64'sd72550100)},
    '{quantize(-64'sd746579), quantize(64'sd4487110), quantize(64'sd95430300)}
  };

  localparam sum_t ROUND_HALF = SUM_W'(longint'(1) << (COEF_FRAC_BITS - 1));

  function automatic prod_t mul(input logic [7:0] ch, input coef_t c);
    return prod_t'(c) * prod_t'($signed({1'b0, ch}));
  endfunction

  function automatic sum_t add3(input prod_t a, input prod_t b, input prod_t c);
    return sum_t'(a) + sum_t'(b) + sum_t'(c);
  endfunction

  // Round half away from zero and clamp to 0..255; a negative sum gives 0.
  function automatic logic [7:0] to_channel(input sum_t s);
    sum_t r;
    r = s + ROUND_HALF;
    if (s[SUM_W-1]) begin
      return 8'd0;
    end else if (|r[SUM_W-1:COEF_FRAC_BITS+8]) begin
      return 8'hFF;
    end else begin
      return r[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
  endfunction

endpackage

// ===== rtl/dichromat_palette_color_map.sv =====
// Top level of the dichromat color map: front end, middle queue and back end.
`timescale 1ns / 1ps
// Maps one 8-bit RGB color to its dichromat rendering and takes a new color every cycle
// in sustained operation while the consumer keeps taking results. An accepted request
// passes in order through the products for the two comparison sums, the middle queue
// write, the matrix products and the output queue write before it shows on the result
// port. Each of the two queues holds four entries; the front end stops taking requests
// when the middle queue together with its product stage is full, and the back end stops
// issuing when the output queue together with its product stage is full, so results
// wait without loss for as long as the consumer stalls.
module dichromat_palette_color_map (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  dpcm_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output dpcm_pkg::out_item_t out_data
);
  import dpcm_pkg::*;

  mq_status_t mq_stat;
  logic       mq_push;
  logic       mq_pop;
  mid_item_t  mq_wr_data;
  mid_item_t  mq_rd_data;

  dpcm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .mq_stat (mq_stat),
    .mq_push (mq_push),
    .mq_data (mq_wr_data)
  );

  dpcm_mid_queue u_mid_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mq_push),
    .push_data (mq_wr_data),
    .pop       (mq_pop),
    .pop_data  (mq_rd_data),
    .stat      (mq_stat)
  );

  dpcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mq_stat   (mq_stat),
    .mq_data   (mq_rd_data),
    .mq_pop    (mq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/dpcm_front.sv =====
// Front end: accepts colors, forms the two comparison sums and picks the half-plane.
`timescale 1ns / 1ps
module dpcm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  dpcm_pkg::in_item_t   in_data,
  input  dpcm_pkg::mq_status_t mq_stat,
  output logic                 mq_push,
  output dpcm_pkg::mid_item_t  mq_data
);
  import dpcm_pkg::*;

  logic     va_r;
  logic     va_nxt;
  in_item_t pix_r;
  prod_t    lo_prod_r [0:2];
  prod_t    hi_prod_r [0:2];
  prod_t    lo_prod_nxt [0:2];
  prod_t    hi_prod_nxt [0:2];
  logic [7:0] ch [0:2];
  sum_t     lo_sum;
  sum_t     hi_sum;
  logic     accept;

  // An item in the product stage still needs a queue slot, so it counts against space.
  assign in_full = (mq_stat.count + CNT_W'(va_r)) >= CNT_W'(QUEUE_DEPTH);
  assign accept  = in_push && !in_full;
  assign va_nxt  = accept;

  always_comb begin
    ch[0] = in_data.red_in;
    ch[1] = in_data.green_in;
    ch[2] = in_data.blue_in;
    for (int j = 0; j < 3; j++) begin
      lo_prod_nxt[j] = mul(ch[j], CMP_LO[j]);
      hi_prod_nxt[j] = mul(ch[j], CMP_HI[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r     <= in_data;
      lo_prod_r <= lo_prod_nxt;
      hi_prod_r <= hi_prod_nxt;
    end
  end

  // A tie between the two sums selects the second matrix.
  assign lo_sum        = add3(lo_prod_r[0], lo_prod_r[1], lo_prod_r[2]);
  assign hi_sum        = add3(hi_prod_r[0], hi_prod_r[1], hi_prod_r[2]);
  assign mq_push       = va_r;
  assign mq_data.pix   = pix_r;
  assign mq_data.plane = !(lo_sum < hi_sum);

endmodule

// ===== rtl/dpcm_mid_queue.sv =====
// Short queue of classified colors between the front end and the back end.
`timescale 1ns / 1ps
module dpcm_mid_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dpcm_pkg::mid_item_t  push_data,
  input  logic                 pop,
  output dpcm_pkg::mid_item_t  pop_data,
  output dpcm_pkg::mq_status_t stat
);
  import dpcm_pkg::*;

  mid_item_t mem_r [0:QUEUE_DEPTH-1];
  ptr_t      wr_ptr_r;
  ptr_t      wr_ptr_nxt;
  ptr_t      rd_ptr_r;
  ptr_t      rd_ptr_nxt;
  cnt_t      cnt_r;
  cnt_t      cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'((wr_ptr_r + 1'b1) % QUEUE_DEPTH) : wr_ptr_r;
    rd_ptr_nxt = pop ? PTR_W'((rd_ptr_r + 1'b1) % QUEUE_DEPTH) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;

endmodule

// ===== rtl/dpcm_back.sv =====
// Back end: applies the selected 3x3 matrix, rounds, clamps and queues the result.
`timescale 1ns / 1ps
module dpcm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dpcm_pkg::mq_status_t mq_stat,
  input  dpcm_pkg::mid_item_t  mq_data,
  output logic                 mq_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output dpcm_pkg::out_item_t  out_data
);
  import dpcm_pkg::*;

  logic       vc_r;
  logic       plane_r;
  prod_t      prod_r [0:2][0:2];
  prod_t      prod_nxt [0:2][0:2];
  logic [7:0] ch [0:2];
  logic [7:0] chan [0:2];
  out_item_t  result;
  out_item_t  oq_mem_r [0:QUEUE_DEPTH-1];
  ptr_t       oq_wr_r;
  ptr_t       oq_wr_nxt;
  ptr_t       oq_rd_r;
  ptr_t       oq_rd_nxt;
  cnt_t       oq_cnt_r;
  cnt_t       oq_cnt_nxt;
  logic       oq_pop;

  // Issue only when the output queue has room for everything already in flight.
  assign mq_pop = !mq_stat.empty && ((oq_cnt_r + CNT_W'(vc_r)) < CNT_W'(QUEUE_DEPTH));

  always_comb begin
    ch[0] = mq_data.pix.red_in;
    ch[1] = mq_data.pix.green_in;
    ch[2] = mq_data.pix.blue_in;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[k][j] = mul(ch[j], mq_data.plane ? MAT_B[k][j] : MAT_A[k][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= mq_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      prod_r  <= prod_nxt;
      plane_r <= mq_data.plane;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      chan[k] = to_channel(add3(prod_r[k][0], prod_r[k][1], prod_r[k][2]));
    end
    result.red_out      = chan[0];
    result.green_out    = chan[1];
    result.blue_out     = chan[2];
    result.plane_select = plane_r;
  end

  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_data  = oq_mem_r[oq_rd_r];

  always_comb begin
    oq_wr_nxt  = vc_r ? PTR_W'((oq_wr_r + 1'b1) % QUEUE_DEPTH) : oq_wr_r;
    oq_rd_nxt  = oq_pop ? PTR_W'((oq_rd_r + 1'b1) % QUEUE_DEPTH) : oq_rd_r;
    oq_cnt_nxt = oq_cnt_r + CNT_W'(vc_r) - CNT_W'(oq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vc_r) begin
      oq_mem_r[oq_wr_r] <= result;
    end
  end

endmodule

// ===== rtl/dpcm_checker.sv =====
// Port-level checker for the dichromat color map and its bind to the top level.
`timescale 1ns / 1ps
module dpcm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input dpcm_pkg::in_item_t  in_data,
  input logic                out_empty,
  input logic                out_pop,
  input dpcm_pkg::out_item_t out_data
);
  import dpcm_pkg::*;

  // Reset leaves the block able to take requests with an empty result side, which the
  // pipeline depth keeps empty while no request can yet have reached it.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full) ##1 out_empty)
    else $error("result side not empty or input full after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished without a pop");

  // The result side only runs dry after the last waiting result was taken.
  a_empty_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_empty) && $past(rst_n)) |-> $past(out_pop))
    else $error("result side went empty without a pop");

endmodule

bind dichromat_palette_color_map dpcm_checker u_dpcm_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the dichromat palette color map.
`timescale 1ns / 1ps
module tb_top;
  import dpcm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_COLORS = 800;
  localparam int DRAIN_CYCLES = 12;

  // Rows of the coefficient table: the two comparison weights, then the two matrices.
  localparam int ROW_LO = 0;
  localparam int ROW_HI = 1;
  localparam int ROW_A = 2;
  localparam int ROW_B = 5;

  class dichromat_scoreboard;
    longint coef [8][3];
    out_item_t pending_colors [$];
    int mismatches;
    int checked;
    int ties;
    int plane_hits [2];

    function new();
      longint e8 [8][3];
      e8 = '{'{999000, 6647390, 73170000},
             '{15338400, 31662400, 5713400},
             '{42633100, 87510200, 8012710},
             '{28110000, 57119500, -3926270},
             '{-1770520, 2700840, 100247000},
             '{75810000, 145387000, -148060000},
             '{11853200, 28759500, 72550100},
             '{-746579, 4487110, 95430300}};
      foreach (e8[i, j]) coef[i][j] = to_fixed(e8[i][j]);
      mismatches = 0;
      checked = 0;
      ties = 0;
      plane_hits[0] = 0;
      plane_hits[1] = 0;
    endfunction

    // Decimal coefficients in units of 1e-8, rounded half away from zero.
    static function longint to_fixed(longint e8);
      longint mag;
      mag = (e8 < 0) ? -e8 : e8;
      mag = ((mag <<< COEF_FRAC_BITS) + 50000000) / 100000000;
      return (e8 < 0) ? -mag : mag;
    endfunction

    function longint weigh(int row, longint r, longint g, longint b);
      return r * coef[row][0] + g * coef[row][1] + b * coef[row][2];
    endfunction

    // Negative means the first matrix applies; zero is a tie.
    function longint balance(longint r, longint g, longint b);
      return weigh(ROW_LO, r, g, b) - weigh(ROW_HI, r, g, b);
    endfunction

    function logic [7:0] channel(longint acc);
      longint v;
      if (acc < 0) begin
        return 8'd0;
      end
      v = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function out_item_t render_dichromat(in_item_t c);
      longint r;
      longint g;
      longint b;
      bit first;
      int base;
      out_item_t o;
      r = c.red_in;
      g = c.green_in;
      b = c.blue_in;
      first = balance(r, g, b) < 0;
      base = first ? ROW_A : ROW_B;
      o.red_out = channel(weigh(base, r, g, b));
      o.green_out = channel(weigh(base + 1, r, g, b));
      o.blue_out = channel(weigh(base + 2, r, g, b));
      o.plane_select = !first;
      return o;
    endfunction

    function void note_color(in_item_t c);
      pending_colors.push_back(render_dichromat(c));
      if (balance(c.red_in, c.green_in, c.blue_in) == 0) begin
        ties++;
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_colors.pop_front();
      checked++;
      plane_hits[got.plane_select]++;
      if (got.red_out !== want.red_out) begin
        report_mismatch($sformatf("red_out %0d, expected %0d", got.red_out, want.red_out));
      end
      if (got.green_out !== want.green_out) begin
        report_mismatch($sformatf("green_out %0d, expected %0d", got.green_out,
                                  want.green_out));
      end
      if (got.blue_out !== want.blue_out) begin
        report_mismatch($sformatf("blue_out %0d, expected %0d", got.blue_out, want.blue_out));
      end
      if (got.plane_select !== want.plane_select) begin
        report_mismatch($sformatf("plane_select %0d, expected %0d", got.plane_select,
                                  want.plane_select));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_item_t in_data;
  logic out_empty;
  logic out_pop;
  out_item_t out_data;

  dichromat_scoreboard sb;
  bit calm;
  int cycle_count = 0;

  dichromat_palette_color_map u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", CYCLE_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic in_item_t rgb(int r, int g, int b);
    in_item_t c;
    c.red_in = r[7:0];
    c.green_in = g[7:0];
    c.blue_in = b[7:0];
    return c;
  endfunction

  // Holds push high until the request is taken, idling now and then beforehand.
  task automatic send_color(input in_item_t c);
    while (!calm && $urandom_range(99) < 8) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_full);
    sb.note_color(c);
  endtask

  // Red value that puts (g, b) on or next to the plane boundary, clamped to range.
  function automatic int boundary_red(int g, int b);
    longint rem;
    longint r;
    rem = sb.balance(0, g, b);
    r = -rem / sb.balance(1, 0, 0);
    return (r < 0) ? 0 : (r > 255) ? 255 : int'(r);
  endfunction

  task automatic run_directed();
    in_item_t colors [$];
    longint rem;
    longint dr;
    int found;
    colors = '{rgb(0, 0, 0), rgb(255, 255, 255), rgb(255, 0, 0), rgb(0, 255, 0),
               rgb(0, 0, 255), rgb(255, 255, 0), rgb(255, 0, 255), rgb(0, 255, 255),
               rgb(1, 1, 1), rgb(254, 254, 254), rgb(128, 128, 128), rgb(1, 0, 0),
               rgb(0, 1, 0), rgb(0, 0, 1), rgb(170, 85, 170), rgb(85, 170, 85)};
    // Exact ties away from black, where both weighted sums agree.
    found = 0;
    dr = sb.balance(1, 0, 0);
    for (int b = 1; b < 256 && found < 3; b++) begin
      for (int g = 0; g < 256 && found < 3; g++) begin
        rem = sb.balance(0, g, b);
        if (rem % dr == 0 && -rem / dr >= 1 && -rem / dr <= 255) begin
          colors.push_back(rgb(int'(-rem / dr), g, b));
          found++;
        end
      end
    end
    foreach (colors[i]) send_color(colors[i]);
  endtask

  task automatic run_random();
    int g;
    int b;
    int kind;
    for (int n = 0; n < RANDOM_COLORS; n++) begin
      calm = (n >= 300 && n < 500);
      kind = $urandom_range(9);
      if (kind < 6) begin
        send_color(rgb($urandom_range(255), $urandom_range(255), $urandom_range(255)));
      end else if (kind < 8) begin
        send_color(rgb($urandom_range(1) ? 255 : $urandom_range(255),
                       $urandom_range(1) ? 0 : 255,
                       $urandom_range(2) == 0 ? $urandom_range(255) : 255 * $urandom_range(1)));
      end else begin
        g = $urandom_range(255);
        b = $urandom_range(255);
        send_color(rgb(boundary_red(g, b) + $urandom_range(2) - 1, g, b));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    wait (rst_n === 1'b1);
    forever begin
      out_pop <= !(!calm && $urandom_range(99) < 8);
      @(posedge clk);
      if (out_pop && !out_empty) begin
        sb.check_result(out_data);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    calm = 1'b0;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_push <= 1'b0;
    while (sb.pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d colors: %0d on the first matrix, %0d on the second, %0d exact ties.",
             sb.checked, sb.plane_hits[0], sb.plane_hits[1], sb.ties);
    $display("Stimulus: primaries, extremes and ties, then %0d random colors with stalls.",
             RANDOM_COLORS);
    if (sb.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dpcm_pkg.sv
rtl/dpcm_front.sv
rtl/dpcm_mid_queue.sv
rtl/dpcm_back.sv
rtl/dichromat_palette_color_map.sv
rtl/dpcm_checker.sv
dv/tb_top.sv
